// ===== rtl/core/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test.
// Used by pip_cell and point_in_polygon_test; depends on nothing.
package pip_pkg;

    // Fewest vertices that still enclose an area.
    localparam int MIN_POLY_VERTICES = 3;

    // Control group that travels with a query token along the cell row.
    typedef struct packed {
        logic valid;   // a query token sits in this stage
        logic parity;  // crossings counted so far, mod 2
        logic pend;    // products of the previous edge await compare
        logic dy_pos;  // previous edge runs upward (dy > 0)
    } tok_ctl_t;

endpackage

// ===== rtl/core/pip_cell.sv =====
// One cell of the edge row: holds one polygon vertex and tests one edge.
// Depends on pip_pkg (tok_ctl_t).
module pip_cell #(
    parameter int CW = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // vertex store
    input  logic                     wr_en,
    input  logic signed [CW-1:0]     wr_x,
    input  logic signed [CW-1:0]     wr_y,
    output logic signed [CW-1:0]     vx,
    output logic signed [CW-1:0]     vy,
    // previous vertex of this cell's edge
    input  logic signed [CW-1:0]     xj,
    input  logic signed [CW-1:0]     yj,
    input  logic                     active,
    // token from the upstream neighbor
    input  pip_pkg::tok_ctl_t        ctl_in,
    input  logic signed [CW-1:0]     px_in,
    input  logic signed [CW-1:0]     py_in,
    input  logic signed [2*CW+1:0]   lhs_in,
    input  logic signed [2*CW+1:0]   rhs_in,
    // token to the downstream neighbor
    output pip_pkg::tok_ctl_t        ctl_out,
    output logic signed [CW-1:0]     px_out,
    output logic signed [CW-1:0]     py_out,
    output logic signed [2*CW+1:0]   lhs_out,
    output logic signed [2*CW+1:0]   rhs_out
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic signed [CW-1:0] vx_reg;
    logic signed [CW-1:0] vy_reg;

    pip_pkg::tok_ctl_t    ctl_reg, ctl_next;
    logic signed [CW-1:0] px_reg, py_reg;
    logic signed [PW-1:0] lhs_reg, lhs_next;
    logic signed [PW-1:0] rhs_reg, rhs_next;

    logic signed [DW-1:0] dx_p, dy_e, dx_e, dy_p;
    logic                 straddle;
    logic                 crossed;

    always_comb
    begin
        // finish the upstream edge: compare the products it left behind
        if (ctl_in.dy_pos)
            crossed = ctl_in.pend && (lhs_in < rhs_in);
        else
            crossed = ctl_in.pend && (rhs_in < lhs_in);

        // start this cell's edge: sign-extended differences, exact products
        dx_p     = DW'(px_in) - DW'(vx_reg);
        dy_e     = DW'(yj) - DW'(vy_reg);
        dx_e     = DW'(xj) - DW'(vx_reg);
        dy_p     = DW'(py_in) - DW'(vy_reg);
        straddle = (vy_reg > py_in) != (yj > py_in);
        lhs_next = PW'(dx_p) * PW'(dy_e);
        rhs_next = PW'(dx_e) * PW'(dy_p);

        ctl_next.valid  = ctl_in.valid;
        ctl_next.parity = ctl_in.parity ^ crossed;
        ctl_next.pend   = ctl_in.valid && active && straddle;
        ctl_next.dy_pos = yj > vy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_in;
        py_reg  <= py_in;
        lhs_reg <= lhs_next;
        rhs_reg <= rhs_next;
        if (wr_en)
        begin
            vx_reg <= wr_x;
            vy_reg <= wr_y;
        end
    end

    assign vx      = vx_reg;
    assign vy      = vy_reg;
    assign ctl_out = ctl_reg;
    assign px_out  = px_reg;
    assign py_out  = py_reg;
    assign lhs_out = lhs_reg;
    assign rhs_out = rhs_reg;

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// Top level of the even-odd point-in-polygon test: a row of edge cells.
// Depends on pip_pkg and pip_cell.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, op, vertex_index,     | one vertex write or query
//          | coord_x, coord_y                          |
//  out     | out_valid, out_ready, inside_res          | one inside flag per query
//  cfg     | cfg_wr_en, cfg_wr_data                    | vertex_count, no wait
//
// A query enters cell 0 on its transfer and moves one cell per cycle through all
// MAX_VERTICES cells, whatever vertex_count is, then passes the finish register
// into the output register. One query is in the row at a time; in_ready drops
// from its transfer until the flag has left the finish register, so a stalled
// output holds off the input as well. A vertex write gives no result. Reset
// clears the control state and vertex_count; vertices stay undefined until
// written.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [$clog2(MAX_VERTICES)-1:0] vertex_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res
);

    localparam int CW    = COORD_WIDTH;
    localparam int PW    = 2 * (CW + 1);
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] n_sat;
    logic [CNT_W-1:0] n_last;
    logic [IDX_W-1:0] wrap_idx;
    logic             enough;

    // token row: stage k feeds cell k, stage MAX_VERTICES is the row's end
    pip_pkg::tok_ctl_t    ctl_w [0:MAX_VERTICES];
    logic signed [CW-1:0] px_w  [0:MAX_VERTICES];
    logic signed [CW-1:0] py_w  [0:MAX_VERTICES];
    logic signed [PW-1:0] lhs_w [0:MAX_VERTICES];
    logic signed [PW-1:0] rhs_w [0:MAX_VERTICES];
    logic signed [CW-1:0] vx_w  [0:MAX_VERTICES-1];
    logic signed [CW-1:0] vy_w  [0:MAX_VERTICES-1];

    logic in_xfer, wr_xfer, out_xfer;
    logic busy;
    logic last_cross;

    logic fin_valid_reg, fin_valid_next;
    logic fin_par_reg,   fin_par_next;
    logic out_valid_reg, out_valid_next;
    logic inside_reg,    inside_next;

    // Clamp an oversize count to the row length.
    assign n_sat    = (int'(count_reg) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : count_reg;
    assign n_last   = n_sat - CNT_W'(1);
    assign wrap_idx = n_last[IDX_W-1:0];
    assign enough   = int'(n_sat) >= pip_pkg::MIN_POLY_VERTICES;

    assign in_xfer  = in_valid && in_ready;
    assign wr_xfer  = in_xfer && (op == OP_WRITE) && (int'(vertex_index) < MAX_VERTICES);
    assign out_xfer = out_valid_reg && out_ready;

    // Inject a fresh token at the head of the row; nothing pends before cell 0.
    always_comb
    begin
        ctl_w[0].valid  = in_xfer && (op == OP_QUERY);
        ctl_w[0].parity = 1'b0;
        ctl_w[0].pend   = 1'b0;
        ctl_w[0].dy_pos = 1'b0;
        px_w[0]         = coord_x;
        py_w[0]         = coord_y;
        lhs_w[0]        = '0;
        rhs_w[0]        = '0;
    end

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            logic signed [CW-1:0] xj_s, yj_s;
            logic                 act_s;
            logic                 wr_s;

            // cell 0 closes the polygon with the last vertex in use
            if (k == 0)
            begin : g_wrap
                assign xj_s = vx_w[wrap_idx];
                assign yj_s = vy_w[wrap_idx];
            end
            else
            begin : g_prev
                assign xj_s = vx_w[k-1];
                assign yj_s = vy_w[k-1];
            end

            assign act_s = k < int'(n_sat);
            assign wr_s  = wr_xfer && (int'(vertex_index) == k);

            pip_cell #(
                .CW(CW)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr_en   (wr_s),
                .wr_x    (coord_x),
                .wr_y    (coord_y),
                .vx      (vx_w[k]),
                .vy      (vy_w[k]),
                .xj      (xj_s),
                .yj      (yj_s),
                .active  (act_s),
                .ctl_in  (ctl_w[k]),
                .px_in   (px_w[k]),
                .py_in   (py_w[k]),
                .lhs_in  (lhs_w[k]),
                .rhs_in  (rhs_w[k]),
                .ctl_out (ctl_w[k+1]),
                .px_out  (px_w[k+1]),
                .py_out  (py_w[k+1]),
                .lhs_out (lhs_w[k+1]),
                .rhs_out (rhs_w[k+1])
            );
        end
    endgenerate

    // Hold off new items while a query is anywhere in the row or the finish slot.
    always_comb
    begin
        busy = fin_valid_reg;
        for (int s = 1; s <= MAX_VERTICES; s++)
        begin
            busy = busy | ctl_w[s].valid;
        end
    end

    assign in_ready = !busy;

    always_comb
    begin
        // compare the products left by the last cell's edge
        if (ctl_w[MAX_VERTICES].dy_pos)
            last_cross = ctl_w[MAX_VERTICES].pend
                         && (lhs_w[MAX_VERTICES] < rhs_w[MAX_VERTICES]);
        else
            last_cross = ctl_w[MAX_VERTICES].pend
                         && (rhs_w[MAX_VERTICES] < lhs_w[MAX_VERTICES]);

        fin_valid_next = fin_valid_reg;
        fin_par_next   = fin_par_reg;
        out_valid_next = out_valid_reg;
        inside_next    = inside_reg;

        // drop the result once the consumer has taken it
        if (out_xfer)
            out_valid_next = 1'b0;

        // advance the finished flag into the output register when it is free
        if (fin_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            inside_next    = fin_par_reg;
            fin_valid_next = 1'b0;
        end

        // catch the token leaving the row; too few vertices reads as outside
        if (ctl_w[MAX_VERTICES].valid)
        begin
            fin_valid_next = 1'b1;
            fin_par_next   = (ctl_w[MAX_VERTICES].parity ^ last_cross) && enough;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_par_reg <= fin_par_next;
        inside_reg  <= inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule
